// ===== design/indexed_stack_engine_core_defines.svh =====
`ifndef INDEXED_STACK_ENGINE_CORE_DEFINES_SVH
`define INDEXED_STACK_ENGINE_CORE_DEFINES_SVH

// Condition that holds at every clock edge outside reset
`define ISE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequence that follows in the cycle after the antecedent
`define ISE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequence that holds in the same cycle as the antecedent
`define ISE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/ise_pkg.sv =====
package ise_pkg;

    localparam int DEPTH     = 8;
    localparam int WORD_BITS = 32;

    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int FUNC_W     = 3;
    localparam int POS_W      = 4;
    localparam int VALUE_W    = 32;
    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int CMP_W      = (COUNT_W > POS_W) ? COUNT_W : POS_W;
    localparam int S_TDATA_W  = ((POS_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = DATA_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH   = 3'd0,
        FN_POP    = 3'd1,
        FN_PEEK   = 3'd2,
        FN_CHANGE = 3'd3,
        FN_DUMP   = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_BADPOS   = 2'd3
    } status_t;

    typedef struct packed {
        logic    load_req;
        logic    push;
        logic    pop;
        logic    change;
        logic    peek_rd;
        logic    dump_start;
        logic    dump_rd;
        logic    ptr_dec;
        logic    emit_imm;
        status_t emit_status;
        logic    emit_ram;
        logic    emit_last;
    } cmd_t;

    typedef struct packed {
        func_t               func;
        logic                full;
        logic                empty;
        logic                pos_ok;
        logic                ptr_zero;
        logic                out_free;
        logic [COUNT_W-1:0]  count;
    } sts_t;

endpackage

// ===== design/ise_ram.sv =====
module ise_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ise_ctrl.sv =====
module ise_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  ise_pkg::sts_t sts,
    output ise_pkg::cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_RDWAIT = 5'b00100,
        S_DUMP   = 5'b01000,
        S_DWAIT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (sts.func)
                    ise_pkg::FN_PUSH:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit_imm = 1'b1;
                            if (sts.full)
                            begin
                                cmd.emit_status = ise_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                cmd.push        = 1'b1;
                                cmd.emit_status = ise_pkg::ST_OK;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    ise_pkg::FN_POP:
                    begin
                        if (sts.out_free)
                        begin
                            if (sts.empty)
                            begin
                                cmd.emit_imm    = 1'b1;
                                cmd.emit_status = ise_pkg::ST_EMPTY;
                                state_next      = S_IDLE;
                            end
                            else
                            begin
                                cmd.pop    = 1'b1;
                                state_next = S_RDWAIT;
                            end
                        end
                    end
                    ise_pkg::FN_PEEK:
                    begin
                        if (sts.out_free)
                        begin
                            if (!sts.pos_ok)
                            begin
                                cmd.emit_imm    = 1'b1;
                                cmd.emit_status = ise_pkg::ST_BADPOS;
                                state_next      = S_IDLE;
                            end
                            else
                            begin
                                cmd.peek_rd = 1'b1;
                                state_next  = S_RDWAIT;
                            end
                        end
                    end
                    ise_pkg::FN_CHANGE:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit_imm = 1'b1;
                            if (!sts.pos_ok)
                            begin
                                cmd.emit_status = ise_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                cmd.change      = 1'b1;
                                cmd.emit_status = ise_pkg::ST_OK;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    ise_pkg::FN_DUMP:
                    begin
                        if (sts.out_free)
                        begin
                            if (sts.empty)
                            begin
                                cmd.emit_imm    = 1'b1;
                                cmd.emit_status = ise_pkg::ST_EMPTY;
                                state_next      = S_IDLE;
                            end
                            else
                            begin
                                cmd.dump_start = 1'b1;
                                state_next     = S_DUMP;
                            end
                        end
                    end
                    default:
                    begin
                        // drop requests with an unused operation code
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_RDWAIT:
            begin
                cmd.emit_ram  = 1'b1;
                cmd.emit_last = 1'b1;
                state_next    = S_IDLE;
            end
            S_DUMP:
            begin
                if (sts.out_free)
                begin
                    cmd.dump_rd = 1'b1;
                    state_next  = S_DWAIT;
                end
            end
            S_DWAIT:
            begin
                cmd.emit_ram  = 1'b1;
                cmd.emit_last = sts.ptr_zero;
                if (sts.ptr_zero)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.ptr_dec = 1'b1;
                    state_next  = S_DUMP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/ise_datapath.sv =====
module ise_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [ise_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [ise_pkg::FUNC_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ise_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [ise_pkg::STATUS_W-1:0]     m_tuser,
    output logic                             m_tlast,
    input  ise_pkg::cmd_t                    cmd,
    output ise_pkg::sts_t                    sts
);

    ise_pkg::func_t                  req_func_reg;
    logic [ise_pkg::POS_W-1:0]       req_pos_reg;
    logic [ise_pkg::VALUE_W-1:0]     req_value_reg;

    logic [ise_pkg::COUNT_W-1:0]     count_reg;
    logic [ise_pkg::COUNT_W-1:0]     count_next;
    logic [ise_pkg::IDX_W-1:0]       ptr_reg;
    logic [ise_pkg::IDX_W-1:0]       ptr_next;

    logic                            m_tvalid_reg;
    logic                            m_tvalid_next;
    ise_pkg::status_t                m_status_reg;
    ise_pkg::status_t                m_status_next;
    logic [ise_pkg::DATA_W-1:0]      m_data_reg;
    logic [ise_pkg::DATA_W-1:0]      m_data_next;
    logic                            m_last_reg;
    logic                            m_last_next;

    logic                            ram_we;
    logic [ise_pkg::IDX_W-1:0]       ram_waddr;
    logic [ise_pkg::WORD_BITS-1:0]   ram_wdata;
    logic                            ram_re;
    logic [ise_pkg::IDX_W-1:0]       ram_raddr;
    logic [ise_pkg::WORD_BITS-1:0]   ram_rdata;

    logic [ise_pkg::IDX_W-1:0]       pos_idx;
    logic [ise_pkg::IDX_W-1:0]       top_idx;
    logic [ise_pkg::CMP_W-1:0]       pos_cmp;
    logic [ise_pkg::CMP_W-1:0]       count_cmp;

    assign pos_idx   = ise_pkg::IDX_W'(req_pos_reg - ise_pkg::POS_W'(1));
    assign top_idx   = ise_pkg::IDX_W'(count_reg - ise_pkg::COUNT_W'(1));
    assign pos_cmp   = ise_pkg::CMP_W'(req_pos_reg);
    assign count_cmp = ise_pkg::CMP_W'(count_reg);

    assign sts.func     = req_func_reg;
    assign sts.full     = (count_reg == ise_pkg::COUNT_W'(ise_pkg::DEPTH));
    assign sts.empty    = (count_reg == '0);
    assign sts.pos_ok   = (pos_cmp != '0) && (pos_cmp <= count_cmp);
    assign sts.ptr_zero = (ptr_reg == '0);
    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign sts.count    = count_reg;

    assign ram_we    = cmd.push || cmd.change;
    assign ram_waddr = cmd.push ? ise_pkg::IDX_W'(count_reg) : pos_idx;
    assign ram_wdata = ise_pkg::WORD_BITS'(req_value_reg);
    assign ram_re    = cmd.pop || cmd.peek_rd || cmd.dump_rd;
    assign ram_raddr = cmd.pop ? top_idx : (cmd.peek_rd ? pos_idx : ptr_reg);

    ise_ram #(
        .WIDTH (ise_pkg::WORD_BITS),
        .DEPTH (ise_pkg::DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + ise_pkg::COUNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - ise_pkg::COUNT_W'(1);
        end

        ptr_next = ptr_reg;
        if (cmd.dump_start)
        begin
            ptr_next = top_idx;
        end
        else if (cmd.ptr_dec)
        begin
            ptr_next = ptr_reg - ise_pkg::IDX_W'(1);
        end

        m_tvalid_next = m_tvalid_reg;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        if (cmd.emit_imm)
        begin
            m_tvalid_next = 1'b1;
            m_status_next = cmd.emit_status;
            m_data_next   = '0;
            m_last_next   = 1'b1;
        end
        else if (cmd.emit_ram)
        begin
            m_tvalid_next = 1'b1;
            m_status_next = ise_pkg::ST_OK;
            m_data_next   = ise_pkg::DATA_W'($signed(ram_rdata));
            m_last_next   = cmd.emit_last;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ptr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            ptr_reg      <= ptr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_func_reg  <= ise_pkg::func_t'(s_tuser);
            req_pos_reg   <= s_tdata[ise_pkg::POS_W-1:0];
            req_value_reg <= s_tdata[ise_pkg::POS_W +: ise_pkg::VALUE_W];
        end
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== design/indexed_stack_engine_core.sv =====
// Indexed LIFO stack of signed words with push, pop, peek, change and dump. One request
// is handled at a time. Push, change, unused operation codes and every request that fails
// its check are decided in the execute state, and their result, where there is one, is
// registered into the output register from that state. Pop and peek read the entry store
// in the execute state and give their result from the read-wait state, as the entry store
// has a registered read port. A dump gives its entries top to bottom, each read in the
// dump state and passed to the output in the dump-wait state, for the same reason.
// The next request is taken once the last result of the previous one sits in the output
// register, which may still be waiting on m_tready; a result held there stalls the next
// result, and with it the next request, for as long as m_tready stays low.
`include "indexed_stack_engine_core_defines.svh"

module indexed_stack_engine_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ise_pkg::S_TDATA_W-1:0] s_tdata,   // position, value, zero fill
    input  logic [ise_pkg::FUNC_W-1:0]    s_tuser,   // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ise_pkg::M_TDATA_W-1:0] m_tdata,   // data
    output logic [ise_pkg::STATUS_W-1:0]  m_tuser,   // status
    output logic                          m_tlast
);

    ise_pkg::cmd_t cmd;
    ise_pkg::sts_t sts;

    ise_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ise_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

    `ISE_ASSERT_ALWAYS(a_count_bound, sts.count <= ise_pkg::COUNT_W'(ise_pkg::DEPTH), "count over depth")
    `ISE_ASSERT_SAME(a_no_push_full, sts.full, !cmd.push, "push on a full stack")
    `ISE_ASSERT_SAME(a_no_pop_empty, sts.empty, !cmd.pop && !cmd.dump_start, "read on empty stack")
    `ISE_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "request taken while busy")

endmodule

// ===== tb/indexed_stack_engine_core_tb.sv =====
module indexed_stack_engine_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ise_pkg::*;

    localparam logic [FUNC_W-1:0] FN_RSVD_LO  = 3'd5;
    localparam logic [FUNC_W-1:0] FN_RSVD_MID = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD_HI  = 3'd7;

    localparam int RAND_ITEMS  = 200;
    localparam int QUIET_ITEMS = 40;
    localparam int FILL_SPAN   = 30;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   data;
        logic                last;
    } stack_result_t;

    typedef struct packed {
        logic [FUNC_W-1:0]   fn;
        logic [POS_W-1:0]    pos;
        logic [VALUE_W-1:0]  val;
        logic                typed;
        stack_result_t       res;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;   // position, value, zero fill
    logic [FUNC_W-1:0]      s_tuser;   // func
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;   // data
    logic [STATUS_W-1:0]    m_tuser;   // status
    logic                   m_tlast;

    logic [DATA_W-1:0]      stack_words [DEPTH];
    logic [COUNT_W-1:0]     held;
    stack_result_t          fresh_results [$];
    stack_result_t          pending_results [$];
    stack_result_t          head_res;
    stim_row_t              dir_rows [$];
    int                     fail_count = 0;
    bit                     no_idle = 1'b0;

    indexed_stack_engine_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic stack_result_t mk_res(status_t st, logic [DATA_W-1:0] dat, logic lst);
        stack_result_t r;
        r.status = st;
        r.data   = dat;
        r.last   = lst;
        return r;
    endfunction

    task automatic stack_predict(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                                 input logic [VALUE_W-1:0] val);
        int  i;
        logic pos_valid;
        fresh_results.delete();
        pos_valid = (pos >= 1) && (pos <= held);
        case (fn)
            FN_PUSH:
                if (held >= DEPTH)
                begin
                    fresh_results.push_back(mk_res(ST_OVERFLOW, '0, 1'b1));
                end
                else
                begin
                    stack_words[held] = val;
                    held = held + 1'b1;
                    fresh_results.push_back(mk_res(ST_OK, '0, 1'b1));
                end
            FN_POP:
                if (held == 0)
                begin
                    fresh_results.push_back(mk_res(ST_EMPTY, '0, 1'b1));
                end
                else
                begin
                    held = held - 1'b1;
                    fresh_results.push_back(mk_res(ST_OK, stack_words[held], 1'b1));
                end
            FN_PEEK:
                if (!pos_valid)
                    fresh_results.push_back(mk_res(ST_BADPOS, '0, 1'b1));
                else
                    fresh_results.push_back(mk_res(ST_OK, stack_words[pos - 1], 1'b1));
            FN_CHANGE:
                if (!pos_valid)
                begin
                    fresh_results.push_back(mk_res(ST_BADPOS, '0, 1'b1));
                end
                else
                begin
                    stack_words[pos - 1] = val;
                    fresh_results.push_back(mk_res(ST_OK, '0, 1'b1));
                end
            FN_DUMP:
                if (held == 0)
                begin
                    fresh_results.push_back(mk_res(ST_EMPTY, '0, 1'b1));
                end
                else
                begin
                    for (i = held; i > 0; i--)
                        fresh_results.push_back(mk_res(ST_OK, stack_words[i - 1], i == 1));
                end
            default:
                ;
        endcase
    endtask

    function automatic void add_row(logic [FUNC_W-1:0] fn, logic [POS_W-1:0] pos,
                                    logic [VALUE_W-1:0] val, logic typed, status_t st,
                                    logic [DATA_W-1:0] dat);
        stim_row_t r;
        r.fn    = fn;
        r.pos   = pos;
        r.val   = val;
        r.typed = typed;
        r.res   = mk_res(st, dat, 1'b1);
        dir_rows.push_back(r);
    endfunction

    task automatic run_row(input stim_row_t r);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.fn;
        s_tdata  <= {{(S_TDATA_W - POS_W - VALUE_W){1'b0}}, r.val, r.pos};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        stack_predict(r.fn, r.pos, r.val);
        if (r.typed)
            pending_results.push_back(r.res);
        else
            foreach (fresh_results[k])
                pending_results.push_back(fresh_results[k]);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 7) != 0)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!no_idle && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                if (fail_count < MAX_REPORTS)
                    $display("unexpected result: status %0d data %h last %b",
                             m_tuser, m_tdata, m_tlast);
                fail_count++;
            end
            else
            begin
                head_res = pending_results.pop_front();
                if (m_tuser !== head_res.status || m_tdata !== head_res.data ||
                    m_tlast !== head_res.last)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("result mismatch: expected status %0d data %h last %b,",
                                 head_res.status, head_res.data, head_res.last,
                                 " got status %0d data %h last %b",
                                 m_tuser, m_tdata, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("indexed_stack_engine_core_tb: errors");
        $finish;
    end

    initial
    begin
        stim_row_t r;
        int        real_sent;
        int        pick;
        int        p_push;
        int        p_pop;
        int        guard;
        bit        fill;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= '0;
        s_tdata  <= '0;
        held = '0;
        foreach (stack_words[k])
            stack_words[k] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(FN_POP,      4'd0,  32'h0,         1'b1, ST_EMPTY,    32'h0);
        add_row(FN_DUMP,     4'd0,  32'h0,         1'b1, ST_EMPTY,    32'h0);
        add_row(FN_PEEK,     4'd1,  32'h0,         1'b1, ST_BADPOS,   32'h0);
        add_row(FN_CHANGE,   4'd0,  32'h1234_5678, 1'b1, ST_BADPOS,   32'h0);
        add_row(FN_RSVD_LO,  4'd1,  32'h0,         1'b0, ST_OK,       32'h0);
        add_row(FN_PUSH,     4'd0,  32'h7fff_ffff, 1'b1, ST_OK,       32'h0);
        add_row(FN_PUSH,     4'd0,  32'h8000_0000, 1'b1, ST_OK,       32'h0);
        add_row(FN_PEEK,     4'd1,  32'h0,         1'b1, ST_OK,       32'h7fff_ffff);
        add_row(FN_PEEK,     4'd2,  32'h0,         1'b1, ST_OK,       32'h8000_0000);
        add_row(FN_PEEK,     4'd0,  32'h0,         1'b1, ST_BADPOS,   32'h0);
        add_row(FN_PEEK,     4'd3,  32'h0,         1'b1, ST_BADPOS,   32'h0);
        add_row(FN_CHANGE,   4'd2,  32'h0,         1'b1, ST_OK,       32'h0);
        add_row(FN_CHANGE,   4'd1,  32'hffff_ffff, 1'b1, ST_OK,       32'h0);
        add_row(FN_DUMP,     4'd0,  32'h0,         1'b0, ST_OK,       32'h0);
        repeat (DEPTH - 2)
            add_row(FN_PUSH, 4'd0,  $urandom,      1'b0, ST_OK,       32'h0);
        add_row(FN_PUSH,     4'd0,  32'h5555_aaaa, 1'b1, ST_OVERFLOW, 32'h0);
        add_row(FN_PEEK,     4'd8,  32'h0,         1'b0, ST_OK,       32'h0);
        add_row(FN_PEEK,     4'd15, 32'h0,         1'b1, ST_BADPOS,   32'h0);
        add_row(FN_CHANGE,   4'd9,  32'haaaa_5555, 1'b1, ST_BADPOS,   32'h0);
        add_row(FN_RSVD_MID, 4'd3,  32'hffff_ffff, 1'b0, ST_OK,       32'h0);
        add_row(FN_RSVD_HI,  4'd15, 32'h8000_0000, 1'b0, ST_OK,       32'h0);
        add_row(FN_DUMP,     4'd0,  32'h0,         1'b0, ST_OK,       32'h0);
        add_row(FN_POP,      4'd0,  32'h0,         1'b0, ST_OK,       32'h0);

        foreach (dir_rows[k])
            run_row(dir_rows[k]);

        real_sent = 0;
        while (real_sent < RAND_ITEMS)
        begin
            no_idle = (real_sent >= RAND_ITEMS - QUIET_ITEMS);
            fill    = ((real_sent / FILL_SPAN) % 2) == 0;
            p_push  = fill ? 45 : 15;
            p_pop   = p_push + (fill ? 10 : 40);
            pick    = $urandom_range(0, 99);
            r.typed = 1'b0;
            r.res   = '0;
            r.val   = pick_value();
            if (held != 0 && $urandom_range(0, 4) != 0)
                r.pos = POS_W'($urandom_range(1, held));
            else
                r.pos = POS_W'($urandom_range(0, 15));
            if (pick < p_push)
                r.fn = FN_PUSH;
            else if (pick < p_pop)
                r.fn = FN_POP;
            else if (pick < p_pop + 18)
                r.fn = FN_PEEK;
            else if (pick < p_pop + 32)
                r.fn = FN_CHANGE;
            else if (pick < p_pop + 42)
                r.fn = FN_DUMP;
            else
            begin
                case ($urandom_range(0, 2))
                    0: r.fn = FN_RSVD_LO;
                    1: r.fn = FN_RSVD_MID;
                    default: r.fn = FN_RSVD_HI;
                endcase
            end
            run_row(r);
            if (r.fn <= FN_DUMP)
                real_sent++;
        end
        s_tvalid <= 1'b0;

        guard = 0;
        while (pending_results.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            if (fail_count < MAX_REPORTS)
                $display("missing results: %0d still awaited", pending_results.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("indexed_stack_engine_core_tb: clean");
        else
            $display("indexed_stack_engine_core_tb: errors");
        $finish;
    end

endmodule

// ===== indexed_stack_engine_core.f =====
+incdir+design
design/ise_pkg.sv
design/ise_ram.sv
design/ise_ctrl.sv
design/ise_datapath.sv
design/indexed_stack_engine_core.sv
tb/indexed_stack_engine_core_tb.sv
